### rtl/core/ritp_pkg.sv
`timescale 1ns / 1ps

package ritp_pkg;

	// Item kinds.
	localparam logic KIND_PREDICT = 1'b0;
	localparam logic KIND_UPDATE  = 1'b1;

	// Branch classes; code seven behaves like "other".
	localparam logic [2:0] CLS_CONDITIONAL   = 3'd0;
	localparam logic [2:0] CLS_DIRECT_CALL   = 3'd2;
	localparam logic [2:0] CLS_INDIRECT      = 3'd3;
	localparam logic [2:0] CLS_INDIRECT_CALL = 3'd4;
	localparam logic [2:0] CLS_RETURN        = 3'd5;

	// Address and call size widths.
	localparam int ADDR_W = 64;
	localparam int SIZE_W = 4;

	// Largest call size that is learned, and the size after reset.
	localparam logic [ADDR_W-1:0] MAX_LEARNED_SIZE = 64'd10;
	localparam logic [SIZE_W-1:0] RESET_CALL_SIZE  = 4'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic capture;
		logic issue;
		logic lookup;
		logic emit;
		logic learn;
	} ritp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic is_predict;
		logic out_free;
	} ritp_status_t;

endpackage

### rtl/core/return_and_indirect_target_predictor.sv
// Return address stack and indirect target table of a branch predictor.
// Input channel (in_valid / in_ready) takes one item per transaction: a
// predict request (kind 0) or a resolved-branch update (kind 1).
// Output channel (out_valid / out_ready) gives one result per predict
// request and none per update.
// Each item passes through four steps: acceptance, one stack and
// indirect table read, one dependent call size read, then the result or
// table write. The next item is accepted in the cycle after the
// previous one finishes, so the block takes no new item while one is in
// flight; the chain of registered memory reads sets the pace.
// A predict result is loaded into the output register in its last step.
// If the receiver stalls and the output register is still full, a finished
// predict waits in its last step and no new item is accepted until the
// output register is free.
// After reset the block clears the indirect table and loads the call size
// table in one pass over max(INDIRECT_ENTRIES, CALL_SIZE_ENTRIES) entries
// (4096 by default) with in_ready low; return stack and history clear at once.
`timescale 1ns / 1ps

module return_and_indirect_target_predictor import ritp_pkg::*; #(
	parameter int RAS_DEPTH         = 32,
	parameter int INDIRECT_ENTRIES  = 4096,
	parameter int CALL_SIZE_ENTRIES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [ADDR_W-1:0] branch_address,
	input  logic [2:0]        branch_class,
	input  logic [ADDR_W-1:0] actual_target,
	input  logic              was_taken,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] predicted_target,
	output logic              predict_taken,
	output logic              covered
);

	ritp_cmd_t    cmd;
	ritp_status_t status;

	// Sequencer.
	ritp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Stack, tables and output register.
	ritp_datapath #(
		.RAS_DEPTH         (RAS_DEPTH),
		.INDIRECT_ENTRIES  (INDIRECT_ENTRIES),
		.CALL_SIZE_ENTRIES (CALL_SIZE_ENTRIES)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.kind             (kind),
		.branch_address   (branch_address),
		.branch_class     (branch_class),
		.actual_target    (actual_target),
		.was_taken        (was_taken),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.predicted_target (predicted_target),
		.predict_taken    (predict_taken),
		.covered          (covered)
	);

`ifndef SYNTHESIS
	// An update never produces a result.
	a_update_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind == KIND_UPDATE) |->
			##1 !$rose(out_valid) ##1 !$rose(out_valid)
			##1 !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("result produced for an update item");

	// A new result is loaded only from the final step of an item.
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result loaded while the block was idle");

	// An accepted item keeps in_ready low until its final step is done.
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("item accepted before the previous one finished");
`endif

endmodule

### rtl/core/ritp_ctrl.sv
`timescale 1ns / 1ps

module ritp_ctrl import ritp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  ritp_status_t status,
	output ritp_cmd_t    cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RD1   = 3'd2;
	localparam logic [2:0] ST_RD2   = 3'd3;
	localparam logic [2:0] ST_EXEC  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_RD1;
				end
			end
			ST_RD1: begin
				cmd.issue = 1'b1;
				state_d   = ST_RD2;
			end
			ST_RD2: begin
				cmd.lookup = 1'b1;
				state_d    = ST_EXEC;
			end
			ST_EXEC: begin
				if (status.is_predict) begin
					if (status.out_free) begin
						cmd.emit = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					cmd.learn = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register; reset starts the table clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/core/ritp_datapath.sv
`timescale 1ns / 1ps

module ritp_datapath import ritp_pkg::*; #(
	parameter int RAS_DEPTH         = 32,
	parameter int INDIRECT_ENTRIES  = 4096,
	parameter int CALL_SIZE_ENTRIES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ritp_cmd_t         cmd,
	output ritp_status_t      status,
	input  logic              kind,
	input  logic [ADDR_W-1:0] branch_address,
	input  logic [2:0]        branch_class,
	input  logic [ADDR_W-1:0] actual_target,
	input  logic              was_taken,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [ADDR_W-1:0] predicted_target,
	output logic              predict_taken,
	output logic              covered
);

	localparam int SW        = $clog2(RAS_DEPTH);
	localparam int IW        = $clog2(INDIRECT_ENTRIES);
	localparam int CSW       = $clog2(CALL_SIZE_ENTRIES);
	localparam int CLR_DEPTH = (INDIRECT_ENTRIES > CALL_SIZE_ENTRIES) ?
		INDIRECT_ENTRIES : CALL_SIZE_ENTRIES;
	localparam int CLRW      = $clog2(CLR_DEPTH);
	localparam int CNTW      = CLRW + 1;

	localparam logic [SW-1:0]   RAS_LAST  = SW'(RAS_DEPTH - 1);
	localparam logic [CLRW-1:0] CLR_LAST  = CLRW'(CLR_DEPTH - 1);
	localparam logic [CNTW-1:0] IND_LIMIT = CNTW'(INDIRECT_ENTRIES);
	localparam logic [CNTW-1:0] CS_LIMIT  = CNTW'(CALL_SIZE_ENTRIES);

	// Captured item.
	logic              kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic [2:0]        cls_q;
	logic [ADDR_W-1:0] actual_q;
	logic              taken_q;

	// Return stack, history and tables.
	logic [ADDR_W-1:0] stk_mem [RAS_DEPTH];
	logic              stk_valid_q [RAS_DEPTH];
	logic [ADDR_W-1:0] stk_rdata_q;
	logic              stk_rvalid_q;
	logic [SW-1:0]     top_q;
	logic [IW-1:0]     hist_q;
	logic [ADDR_W-1:0] ind_mem [INDIRECT_ENTRIES];
	logic [ADDR_W-1:0] ind_rdata_q;
	logic [SIZE_W-1:0] cs_mem [CALL_SIZE_ENTRIES];
	logic [SIZE_W-1:0] cs_rdata_q;
	logic [ADDR_W-1:0] diff_q;
	logic [CLRW-1:0]   clr_cnt_q;
	logic              out_valid_q;

	// Decode of the captured item.
	logic              is_call;
	logic              is_ind;
	logic              is_ret;
	logic              is_cond;
	logic              is_pred;
	logic              push;
	logic              pop;
	logic [IW-1:0]     slot;
	logic [SW-1:0]     top_next;
	logic [SW-1:0]     top_prev;
	logic [ADDR_W-1:0] top_val;
	logic              clr_ind;
	logic              clr_cs;
	logic              learn_ok;

	assign is_call  = (cls_q == CLS_DIRECT_CALL) || (cls_q == CLS_INDIRECT_CALL);
	assign is_ind   = (cls_q == CLS_INDIRECT) || (cls_q == CLS_INDIRECT_CALL);
	assign is_ret   = (cls_q == CLS_RETURN);
	assign is_cond  = (cls_q == CLS_CONDITIONAL);
	assign is_pred  = (kind_q == KIND_PREDICT);
	assign push     = is_pred && is_call;
	assign pop      = !is_pred && is_ret;
	assign slot     = addr_q[IW+1:2] ^ hist_q;
	assign top_next = (top_q == RAS_LAST) ? '0 : top_q + SW'(1);
	assign top_prev = (top_q == '0) ? RAS_LAST : top_q - SW'(1);
	assign top_val  = stk_rvalid_q ? stk_rdata_q : '0;
	assign clr_ind  = {1'b0, clr_cnt_q} < IND_LIMIT;
	assign clr_cs   = {1'b0, clr_cnt_q} < CS_LIMIT;
	assign learn_ok = pop && (diff_q <= MAX_LEARNED_SIZE);

	assign status.clr_last   = (clr_cnt_q == CLR_LAST);
	assign status.is_predict = is_pred;
	assign status.out_free   = !out_valid_q || out_ready;

	// Item capture at acceptance.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= kind;
			addr_q   <= branch_address;
			cls_q    <= branch_class;
			actual_q <= actual_target;
			taken_q  <= was_taken;
		end
	end

	// Return stack storage: push writes, the top is read before any pop.
	always_ff @(posedge clk) begin
		if (cmd.issue && push) begin
			stk_mem[top_next] <= addr_q;
		end
		if (cmd.issue) begin
			stk_rdata_q <= stk_mem[top_q];
		end
	end

	// Stack pointer, entry valid bits and direction history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q        <= '0;
			hist_q       <= '0;
			stk_rvalid_q <= 1'b0;
			for (int i = 0; i < RAS_DEPTH; i++) begin
				stk_valid_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.issue && push) begin
				stk_valid_q[top_next] <= 1'b1;
				top_q                 <= top_next;
			end else if (cmd.lookup && pop) begin
				stk_valid_q[top_q] <= 1'b0;
				top_q              <= top_prev;
			end
			if (cmd.issue) begin
				stk_rvalid_q <= stk_valid_q[top_q];
			end
			if (cmd.issue && !is_pred && is_cond) begin
				hist_q <= {hist_q[IW-2:0], taken_q};
			end
		end
	end

	// Indirect target table: cleared after reset, written on update.
	always_ff @(posedge clk) begin
		if (cmd.clear && clr_ind) begin
			ind_mem[clr_cnt_q[IW-1:0]] <= '0;
		end else if (cmd.issue && !is_pred && is_ind) begin
			ind_mem[slot] <= actual_q;
		end
		if (cmd.issue) begin
			ind_rdata_q <= ind_mem[slot];
		end
	end

	// Call size table: set to the reset size, relearned on return updates.
	always_ff @(posedge clk) begin
		if (cmd.clear && clr_cs) begin
			cs_mem[clr_cnt_q[CSW-1:0]] <= RESET_CALL_SIZE;
		end else if (cmd.learn && learn_ok) begin
			cs_mem[top_val[CSW-1:0]] <= diff_q[SIZE_W-1:0];
		end
		if (cmd.lookup) begin
			cs_rdata_q <= cs_mem[top_val[CSW-1:0]];
		end
	end

	// Distance between the popped call address and the resolved target.
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			diff_q <= (top_val > actual_q) ? top_val - actual_q : actual_q - top_val;
		end
	end

	// Clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear) begin
			clr_cnt_q <= clr_cnt_q + CLRW'(1);
		end
	end

	// Output register; holds the result until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (is_ret) begin
				predicted_target <= top_val + ADDR_W'(cs_rdata_q);
			end else if (is_ind) begin
				predicted_target <= ind_rdata_q;
			end else begin
				predicted_target <= '0;
			end
			predict_taken <= !is_cond;
			covered       <= is_ret || is_ind;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import ritp_pkg::*;

	// Branch classes that the package leaves unnamed.
	localparam logic [2:0] CLS_DIRECT_JUMP = 3'd1;
	localparam logic [2:0] CLS_OTHER       = 3'd6;
	localparam logic [2:0] CLS_UNUSED      = 3'd7;

	localparam int RAS_N          = 32;
	localparam int IND_N          = 4096;
	localparam int SIZE_N         = 1024;
	localparam int RANDOM_ITEMS   = 1225;
	localparam int DRAIN_AT       = 700;
	localparam int HOLD_AFTER     = 150;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 20000;

	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] TOP_ADDR = 64'hFFFF_FFFF_FFFF_FFFE;
	localparam logic [63:0] IND_ADDR = 64'h0000_1234_5678_9ABC;

	typedef struct packed {
		logic        kind;
		logic [63:0] addr;
		logic [2:0]  cls;
		logic [63:0] actual;
		logic        taken;
	} branch_t;

	typedef struct packed {
		logic [63:0] target;
		logic        taken;
		logic        cov;
	} prediction_t;

	typedef struct packed {
		branch_t     br;
		logic        fixed;
		prediction_t want;
	} row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              kind;
	logic [63:0]       branch_address;
	logic [2:0]        branch_class;
	logic [63:0]       actual_target;
	logic              was_taken;
	logic              out_valid;
	logic              out_ready;
	logic [63:0]       predicted_target;
	logic              predict_taken;
	logic              covered;

	// Predictor state, kept in step with every accepted transaction.
	logic [63:0] ras [RAS_N];
	logic [4:0]  ras_top;
	logic [63:0] ind_tbl [IND_N];
	logic [11:0] hist;
	logic [3:0]  call_size [SIZE_N];

	prediction_t pending_predictions[$];
	logic [63:0] addr_pool [8];

	int n_errors;
	int n_results;
	int n_predicts;
	int n_updates;
	int n_learned;
	int burst_left;
	int idle_cycles;

	return_and_indirect_target_predictor u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.kind             (kind),
		.branch_address   (branch_address),
		.branch_class     (branch_class),
		.actual_target    (actual_target),
		.was_taken        (was_taken),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.predicted_target (predicted_target),
		.predict_taken    (predict_taken),
		.covered          (covered)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Computes the prediction for one branch and applies its training.
	// Returns 1 when the transaction produces a result.
	function automatic bit predict_and_train(input branch_t b, output prediction_t p);
		logic [63:0] top_addr;
		logic [63:0] popped;
		logic [63:0] distance;
		logic [11:0] slot;
		bit          indir;
		indir = (b.cls == CLS_INDIRECT) || (b.cls == CLS_INDIRECT_CALL);
		slot = b.addr[13:2] ^ hist;
		p = '0;
		if (b.kind == KIND_PREDICT) begin
			// Calls push their own address; the oldest entry is lost on overflow.
			if (b.cls == CLS_DIRECT_CALL || b.cls == CLS_INDIRECT_CALL) begin
				ras_top = ras_top + 5'd1;
				ras[ras_top] = b.addr;
			end
			if (b.cls == CLS_RETURN) begin
				top_addr = ras[ras_top];
				p.target = top_addr + {60'd0, call_size[top_addr[9:0]]};
				p.cov = 1'b1;
			end else if (indir) begin
				p.target = ind_tbl[slot];
				p.cov = 1'b1;
			end
			p.taken = (b.cls != CLS_CONDITIONAL);
			return 1'b1;
		end
		if (indir)
			ind_tbl[slot] = b.actual;
		if (b.cls == CLS_CONDITIONAL)
			hist = {hist[10:0], b.taken};
		// A return pops and relearns the call size when the distance is short.
		if (b.cls == CLS_RETURN) begin
			popped = ras[ras_top];
			ras[ras_top] = '0;
			ras_top = ras_top - 5'd1;
			distance = (popped > b.actual) ? popped - b.actual : b.actual - popped;
			if (distance <= MAX_LEARNED_SIZE) begin
				call_size[popped[9:0]] = distance[3:0];
				n_learned++;
			end
		end
		return 1'b0;
	endfunction

	function automatic row_t row(input logic k, input logic [63:0] a, input logic [2:0] c,
			input logic [63:0] act, input logic tk, input logic fx,
			input logic [63:0] t, input logic pt, input logic cv);
		row_t r;
		r.br = '{kind: k, addr: a, cls: c, actual: act, taken: tk};
		r.fixed = fx;
		r.want = '{target: t, taken: pt, cov: cv};
		return r;
	endfunction

	// Offers one transaction, with bursts and gaps, and records its prediction.
	task automatic send_branch(input branch_t b, input logic fixed, input prediction_t want);
		prediction_t p;
		int          gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 12);
		end
		burst_left--;
		in_valid       <= 1'b1;
		kind           <= b.kind;
		branch_address <= b.addr;
		branch_class   <= b.cls;
		actual_target  <= b.actual;
		was_taken      <= b.taken;
		do @(posedge clk); while (!in_ready);
		if (predict_and_train(b, p)) begin
			pending_predictions.push_back(fixed ? want : p);
			n_predicts++;
		end else begin
			n_updates++;
		end
	endtask

	// Mostly call/return and indirect train/lookup traffic, with some noise.
	task automatic make_random_branch(output branch_t b);
		int sel;
		int off;
		b.kind = 1'($urandom_range(0, 1));
		b.addr = rand64();
		b.cls = 3'($urandom_range(0, 7));
		b.actual = rand64();
		b.taken = 1'($urandom_range(0, 1));
		sel = $urandom_range(0, 99);
		if (sel < 18) begin
			b.kind = KIND_PREDICT;
			b.cls = ($urandom_range(0, 2) == 0) ? CLS_INDIRECT_CALL : CLS_DIRECT_CALL;
			if ($urandom_range(0, 1) == 1)
				b.addr = addr_pool[3'($urandom_range(0, 7))] + 64'($urandom_range(0, 3));
		end else if (sel < 33) begin
			b.kind = KIND_PREDICT;
			b.cls = CLS_RETURN;
		end else if (sel < 50) begin
			b.kind = KIND_UPDATE;
			b.cls = CLS_RETURN;
			off = $urandom_range(0, 24) - 12;
			if ($urandom_range(0, 9) != 0)
				b.actual = ras[ras_top] + {{32{off[31]}}, off[31:0]};
		end else if (sel < 62) begin
			b.kind = KIND_PREDICT;
			b.cls = CLS_INDIRECT;
			b.addr = addr_pool[3'($urandom_range(0, 7))];
		end else if (sel < 74) begin
			b.kind = KIND_UPDATE;
			b.cls = ($urandom_range(0, 1) == 1) ? CLS_INDIRECT : CLS_INDIRECT_CALL;
			b.addr = addr_pool[3'($urandom_range(0, 7))];
		end else if (sel < 88) begin
			b.cls = CLS_CONDITIONAL;
		end
	endtask

	// Receiver: ready patterns in segments, plus one long hold-off.
	initial begin
		int  mode;
		int  seg;
		bit  held;
		out_ready = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			seg = $urandom_range(20, 120);
			mode = $urandom_range(0, 2);
			repeat (seg) begin
				@(posedge clk);
				if (!held && n_results >= HOLD_AFTER) begin
					held = 1'b1;
					out_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end else begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						default: out_ready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	// Result checker: each transaction is compared with the oldest prediction.
	always @(posedge clk) begin
		prediction_t want;
		if (out_valid && out_ready) begin
			n_results++;
			if (pending_predictions.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result: expected none, actual target %h taken %b covered %b",
					$time, predicted_target, predict_taken, covered);
			end else begin
				want = pending_predictions.pop_front();
				if (predicted_target !== want.target) begin
					n_errors++;
					$display("%0t: predicted_target expected %h actual %h",
						$time, want.target, predicted_target);
				end
				if (predict_taken !== want.taken) begin
					n_errors++;
					$display("%0t: predict_taken expected %b actual %b",
						$time, want.taken, predict_taken);
				end
				if (covered !== want.cov) begin
					n_errors++;
					$display("%0t: covered expected %b actual %b", $time, want.cov, covered);
				end
			end
		end
	end

	// Watchdog on cycles without any transaction on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: timeout, %0d predictions still pending", $time,
				pending_predictions.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		row_t        dir_tbl[$];
		branch_t     b;
		prediction_t no_want;
		int          i;

		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_PREDICT;
		branch_address = '0;
		branch_class = CLS_CONDITIONAL;
		actual_target = '0;
		was_taken = 1'b0;
		n_errors = 0;
		n_results = 0;
		n_predicts = 0;
		n_updates = 0;
		n_learned = 0;
		burst_left = 0;
		idle_cycles = 0;
		no_want = '0;

		// Predictor reset state.
		for (i = 0; i < RAS_N; i++)
			ras[i] = '0;
		for (i = 0; i < IND_N; i++)
			ind_tbl[i] = '0;
		for (i = 0; i < SIZE_N; i++)
			call_size[i] = RESET_CALL_SIZE;
		ras_top = '0;
		hist = '0;
		for (i = 0; i < 8; i++)
			addr_pool[i] = (i < 2) ? (rand64() & ~64'h3FF) : rand64();

		// Directed rows; a fixed expectation is given where it is obvious.
		dir_tbl.push_back(row(KIND_PREDICT, '0, CLS_RETURN, '0, 0, 1, 64'd4, 1, 1));
		dir_tbl.push_back(row(KIND_PREDICT, ALL_ONES, CLS_CONDITIONAL, ALL_ONES, 1, 1, '0, 0, 0));
		dir_tbl.push_back(row(KIND_PREDICT, ALL_ONES, CLS_INDIRECT, '0, 0, 1, '0, 1, 1));
		dir_tbl.push_back(row(KIND_PREDICT, ALL_ONES, CLS_UNUSED, ALL_ONES, 1, 1, '0, 1, 0));
		dir_tbl.push_back(row(KIND_PREDICT, IND_ADDR, CLS_DIRECT_JUMP, '0, 0, 1, '0, 1, 0));
		dir_tbl.push_back(row(KIND_PREDICT, IND_ADDR, CLS_OTHER, ALL_ONES, 1, 1, '0, 1, 0));
		// Pop of an empty stack, then a return prediction after the wrap.
		dir_tbl.push_back(row(KIND_UPDATE, '0, CLS_RETURN, '0, 0, 0, '0, 0, 0));
		dir_tbl.push_back(row(KIND_PREDICT, '0, CLS_RETURN, '0, 0, 0, '0, 0, 0));
		// Return target sum that wraps past the top of the address space.
		dir_tbl.push_back(row(KIND_PREDICT, TOP_ADDR, CLS_DIRECT_CALL, '0, 0, 1, '0, 1, 0));
		dir_tbl.push_back(row(KIND_PREDICT, '0, CLS_RETURN, '0, 0, 0, '0, 0, 0));
		dir_tbl.push_back(row(KIND_UPDATE, '0, CLS_RETURN, TOP_ADDR - 64'd10, 0, 0, '0, 0, 0));
		dir_tbl.push_back(row(KIND_PREDICT, TOP_ADDR, CLS_DIRECT_CALL, '0, 0, 0, '0, 0, 0));
		dir_tbl.push_back(row(KIND_PREDICT, '0, CLS_RETURN, '0, 0, 0, '0, 0, 0));
		// Distance of eleven leaves the call size alone.
		dir_tbl.push_back(row(KIND_PREDICT, 64'h1000, CLS_DIRECT_CALL, '0, 0, 0, '0, 0, 0));
		dir_tbl.push_back(row(KIND_UPDATE, '0, CLS_RETURN, 64'h100B, 1, 0, '0, 0, 0));
		dir_tbl.push_back(row(KIND_PREDICT, 64'h1000, CLS_DIRECT_CALL, '0, 0, 0, '0, 0, 0));
		dir_tbl.push_back(row(KIND_PREDICT, '0, CLS_RETURN, '0, 0, 0, '0, 0, 0));
		// Indirect train and lookup, then a history shift moves the slot.
		dir_tbl.push_back(row(KIND_PREDICT, IND_ADDR, CLS_INDIRECT_CALL, '0, 0, 0, '0, 0, 0));
		dir_tbl.push_back(row(KIND_UPDATE, IND_ADDR, CLS_INDIRECT, ALL_ONES, 1, 0, '0, 0, 0));
		dir_tbl.push_back(row(KIND_PREDICT, IND_ADDR, CLS_INDIRECT, '0, 0, 0, '0, 0, 0));
		dir_tbl.push_back(row(KIND_UPDATE, IND_ADDR, CLS_CONDITIONAL, '0, 1, 0, '0, 0, 0));
		dir_tbl.push_back(row(KIND_PREDICT, IND_ADDR, CLS_INDIRECT_CALL, '0, 0, 0, '0, 0, 0));
		// Updates of classes that train nothing.
		dir_tbl.push_back(row(KIND_UPDATE, IND_ADDR, CLS_DIRECT_JUMP, ALL_ONES, 1, 0, '0, 0, 0));
		dir_tbl.push_back(row(KIND_UPDATE, IND_ADDR, CLS_OTHER, ALL_ONES, 1, 0, '0, 0, 0));
		dir_tbl.push_back(row(KIND_UPDATE, IND_ADDR, CLS_UNUSED, ALL_ONES, 1, 0, '0, 0, 0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tbl[i])
			send_branch(dir_tbl[i].br, dir_tbl[i].fixed, dir_tbl[i].want);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			// Once, the sender pauses until every prediction has come back.
			if (i == DRAIN_AT) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_predictions.size() != 0);
				burst_left = 0;
			end
			make_random_branch(b);
			send_branch(b, 1'b0, no_want);
		end
		in_valid <= 1'b0;

		while (pending_predictions.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Sent %0d predict and %0d update transactions, checked %0d results.",
			n_predicts, n_updates, n_results);
		$display("Call sizes relearned %0d times; stack wrap and indirect retraining exercised.",
			n_learned);
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### filelist.f
rtl/core/ritp_pkg.sv
rtl/core/ritp_ctrl.sv
rtl/core/ritp_datapath.sv
rtl/core/return_and_indirect_target_predictor.sv
verif/tb.sv
